@@ hw/rtl/quicksort_block_sorter_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the block sorter.
// Concurrent checks in simulation; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef QUICKSORT_BLOCK_SORTER_UNIT_MACROS_SVH
`define QUICKSORT_BLOCK_SORTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define QSBS_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("block sorter check failed");

// Next-cycle implication, checked outside reset.
`define QSBS_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("block sorter check failed");

`else

`define QSBS_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define QSBS_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

@@ hw/rtl/qsbs_pkg.sv @@
// ----------------------------------------------------------------------------
// qsbs_pkg
// Types and constants shared by the block sorter modules.
// ----------------------------------------------------------------------------
package qsbs_pkg;

    // Number of elements one block can hold.
    localparam int DEPTH = 64;
    // Width of the element count, which must reach DEPTH itself.
    localparam int CNT_W = $clog2(DEPTH + 1);

    // One input beat.
    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               last_res;
        logic               truncated;
    } result_t;

    // Controller states.
    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    // Commands broadcast from the controller to every cell.
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_cmd_t;

endpackage

@@ hw/rtl/qsbs_cell.sv @@
// ----------------------------------------------------------------------------
// qsbs_cell
// One cell of the sorting chain: holds one element and its valid flag.
// ----------------------------------------------------------------------------
module qsbs_cell
    import qsbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_cmd_t          cmd,
    input  logic signed [31:0] new_value,
    input  logic               prev_lt,
    input  logic signed [31:0] prev_value,
    input  logic               prev_valid,
    input  logic signed [31:0] next_value,
    input  logic               next_valid,
    output logic               lt,
    output logic signed [31:0] value,
    output logic               valid
);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic               valid_reg;
    logic               valid_next;

    // An empty cell counts as larger than any value.
    assign lt = !valid_reg || (new_value < value_reg);

    // On insert, cells above the insertion point move up by one; the cell at
    // the insertion point takes the new value. On shift, the chain moves down.
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (cmd.shift)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
        else if (cmd.insert && lt)
        begin
            if (prev_lt)
            begin
                value_next = prev_value;
                valid_next = prev_valid;
            end
            else
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
        end
    end

    // Element payload.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

@@ hw/rtl/qsbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// qsbs_ctrl
// Load and emit sequencer: counts elements, tracks overflow, drives the chain.
// ----------------------------------------------------------------------------
module qsbs_ctrl
    import qsbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      item_last,
    output logic      busy,
    output logic      done,
    output logic      last_res,
    output logic      truncated,
    output cell_cmd_t cmd
);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               accept;
    logic               has_room;

    assign has_room = (count_reg < CNT_W'(DEPTH));

    // State register and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Next state and outputs. While emitting, the count holds the number of
    // elements still in the chain.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        accept     = 1'b0;
        busy       = 1'b0;
        done       = 1'b0;
        last_res   = 1'b0;
        truncated  = ovf_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD:
            begin
                accept = start;
                if (accept)
                begin
                    if (has_room)
                    begin
                        cmd.insert = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item_last)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                busy       = 1'b1;
                done       = 1'b1;
                cmd.shift  = 1'b1;
                last_res   = (count_reg == CNT_W'(1));
                count_next = count_reg - CNT_W'(1);
                if (last_res)
                begin
                    state_next = ST_LOAD;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

@@ hw/rtl/quicksort_block_sorter_unit.sv @@
// ----------------------------------------------------------------------------
// quicksort_block_sorter_unit
// Block sorter for signed 32-bit values. Elements are loaded one beat per
// cycle while busy is low into a chain of cells that keeps them in ascending
// order at all times: each cell compares the incoming value with its own and
// either keeps its element, takes the new value, or takes its lower
// neighbor's element. Start may stay high. The beat marked last ends the
// block; busy then rises and the block streams out smallest first on
// consecutive cycles, one result beat per stored element, marked by done for
// exactly one cycle each; the receiver cannot stall it. A block is emitted
// by shifting down the cell chain, and a new block may start on the cycle
// after the final beat. Up to 64 elements are held; further beats are
// dropped and every result of that block carries truncated. Duplicates are
// kept.
// ----------------------------------------------------------------------------
`include "quicksort_block_sorter_unit_macros.svh"

module quicksort_block_sorter_unit
    import qsbs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    done,
    output result_t result
);

    cell_cmd_t          cmd;
    logic               last_res;
    logic               truncated;
    logic               cell_lt    [DEPTH];
    logic signed [31:0] cell_value [DEPTH];
    logic               cell_valid [DEPTH];

    // Sequencer.
    qsbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item_last (item.last),
        .busy      (busy),
        .done      (done),
        .last_res  (last_res),
        .truncated (truncated),
        .cmd       (cmd)
    );

    // Chain of sorting cells; cell 0 holds the smallest element.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic               prev_lt;
        logic signed [31:0] prev_value;
        logic               prev_valid;
        logic signed [31:0] next_value;
        logic               next_valid;

        if (i == 0)
        begin : g_first
            assign prev_lt    = 1'b0;
            assign prev_value = '0;
            assign prev_valid = 1'b0;
        end
        else
        begin : g_mid
            assign prev_lt    = cell_lt[i-1];
            assign prev_value = cell_value[i-1];
            assign prev_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_value = '0;
            assign next_valid = 1'b0;
        end
        else
        begin : g_inner
            assign next_value = cell_value[i+1];
            assign next_valid = cell_valid[i+1];
        end

        qsbs_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .new_value  (item.value),
            .prev_lt    (prev_lt),
            .prev_value (prev_value),
            .prev_valid (prev_valid),
            .next_value (next_value),
            .next_valid (next_valid),
            .lt         (cell_lt[i]),
            .value      (cell_value[i]),
            .valid      (cell_valid[i])
        );
    end

    // Result beat comes straight from the head of the chain.
    assign result.sorted_value = cell_value[0];
    assign result.last_res     = last_res;
    assign result.truncated    = truncated;

    // A result beat always carries a stored element.
    `QSBS_ASSERT_IMPLY(a_done_head_valid, clk, rst_n, done, cell_valid[0])
    // A last input beat starts the emit phase.
    `QSBS_ASSERT_NEXT(a_last_starts_emit, clk, rst_n, start && !busy && item.last, busy)
    // Result beats of one block are back to back.
    `QSBS_ASSERT_NEXT(a_emit_contiguous, clk, rst_n, done && !result.last_res, done)
    // After the final result beat the chain is empty and loading resumes.
    `QSBS_ASSERT_NEXT(a_final_empties, clk, rst_n, done && result.last_res,
                      !busy && !cell_valid[0])

endmodule
